// ===== hw/rtl/bmffa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Block map allocator package
// Shared payload types, result codes and sequencer states for the first-fit
// block map allocator.
// ----------------------------------------------------------------------------
package bmffa_pkg;

	// Request opcodes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_ALLOC_FAIL = 2'd1;
	localparam logic [1:0] STAT_FREE_ERR   = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [23:0] size_bytes;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_A_RD,
		S_A_EV,
		S_A_SPLIT,
		S_A_HEAD,
		S_A_MUL,
		S_A_ADD,
		S_F_RD,
		S_F_EV,
		S_P_RD,
		S_P_EV,
		S_P_ZERO,
		S_N_RD,
		S_N_EV,
		S_N_ZERO,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bmffa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bmffa_ram #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/block_map_first_fit_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// First-fit block map allocator
// Allocates and frees runs of fixed-size blocks over a segment map held in
// RAM, with coalescing of neighboring free segments on free.
// ----------------------------------------------------------------------------
// After reset the block initializes the segment map (one entry a cycle) and
// takes no request meanwhile; data_base may be written at any time the block
// is idle. Each request is handled alone: in the S_DIV state a range check and
// a multiply by the rounded-up reciprocal of the block size turn the byte size
// or address offset into blocks, then a sequencer walks the map through the
// RAM's single read port, with a read state and an evaluate state per entry
// visited. An allocate that finds a fitting segment writes the remainder head
// when the segment is split, then the allocated head, then forms the address;
// a free marks its segment free, scans back to the previous segment head and
// merges with a free previous and next segment. The block returns to idle
// after each result transfer before the next request is taken.
module block_map_first_fit_allocator #(
	parameter int unsigned NUM_BLOCKS  = 1024,
	parameter int unsigned BLOCK_BYTES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire bmffa_pkg::req_t  in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output bmffa_pkg::rsp_t       out_data,
	input  wire logic             cfg_we,
	input  wire logic [31:0]      cfg_wdata
);

	import bmffa_pkg::*;

	localparam int unsigned AW  = $clog2(NUM_BLOCKS);
	localparam int unsigned IW  = AW + 1;
	localparam int unsigned EW  = AW + 2;
	localparam int unsigned BBW = $clog2(BLOCK_BYTES + 1);
	localparam int unsigned PW  = AW + BBW;

	// Reciprocal division: every dividend that passes the range check is
	// below 2^XW, which makes floor(x * RECIP / 2^SH) exact.
	localparam int unsigned XW  = $clog2((NUM_BLOCKS + 1) * BLOCK_BYTES);
	localparam int unsigned LW  = $clog2(BLOCK_BYTES);
	localparam int unsigned SH  = XW + LW;
	localparam int unsigned RW  = XW + 2;
	localparam int unsigned MW  = XW + RW;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

	localparam logic [IW-1:0]  NB_I     = IW'(NUM_BLOCKS);
	localparam logic [EW-1:0]  NB_E     = EW'(NUM_BLOCKS);
	localparam logic [AW-1:0]  CLR_LAST = AW'(NUM_BLOCKS - 1);
	localparam logic [PW-1:0]  BB_P     = PW'(BLOCK_BYTES);
	localparam logic [RW-1:0]  RECIP_R  = RW'(RECIP);
	localparam logic [31:0]    BB_M1    = 32'(BLOCK_BYTES - 1);
	localparam logic [31:0]    LIM_A    = 32'((NUM_BLOCKS + 1) * BLOCK_BYTES);
	localparam logic [31:0]    LIM_F    = 32'(NUM_BLOCKS * BLOCK_BYTES);

	state_t              st_q, st_d;
	logic [31:0]         data_base_q;
	logic [AW-1:0]       clr_q, clr_d;

	logic                op_q, op_d;
	logic [31:0]         div_q, div_d;
	logic [IW-1:0]       need_q, need_d;
	logic [IW-1:0]       cur_q, cur_d;
	logic [IW-1:0]       p_q, p_d;
	logic [EW-1:0]       val_q, val_d;
	logic [PW-1:0]       prod_q, prod_d;
	logic [1:0]          stat_q, stat_d;
	logic [31:0]         raddr_q, raddr_d;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [EW-1:0]       ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;

	bmffa_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready                = (st_q == S_IDLE);
	assign out_valid               = (st_q == S_DONE);
	assign out_data.status         = stat_q;
	assign out_data.result_address = raddr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLEAR;
			clr_q       <= '0;
			data_base_q <= '0;
		end else begin
			st_q  <= st_d;
			clr_q <= clr_d;
			if (cfg_we) begin
				data_base_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		div_q   <= div_d;
		need_q  <= need_d;
		cur_q   <= cur_d;
		p_q     <= p_d;
		val_q   <= val_d;
		prod_q  <= prod_d;
		stat_q  <= stat_d;
		raddr_q <= raddr_d;
	end

	always_comb begin
		logic [MW-1:0]  mul_p;
		logic [IW-1:0]  quot;
		logic [31:0]    lim;
		logic           rd_neg;
		logic           rd_pos;
		logic [EW-1:0]  rd_abs;
		logic [IW-1:0]  mag;
		logic [IW-1:0]  nxt;

		st_d    = st_q;
		clr_d   = clr_q;
		op_d    = op_q;
		div_d   = div_q;
		need_d  = need_q;
		cur_d   = cur_q;
		p_d     = p_q;
		val_d   = val_q;
		prod_d  = prod_q;
		stat_d  = stat_q;
		raddr_d = raddr_q;

		ram_we    = 1'b0;
		ram_waddr = cur_q[AW-1:0];
		ram_wdata = '0;
		ram_raddr = cur_q[AW-1:0];

		mul_p  = {{RW{1'b0}}, div_q[XW-1:0]} * {{XW{1'b0}}, RECIP_R};
		quot   = mul_p[SH +: IW];
		lim    = (op_q == OP_ALLOC) ? LIM_A : LIM_F;
		rd_neg = ram_rdata[EW-1];
		rd_pos = !ram_rdata[EW-1] && (ram_rdata != '0);
		rd_abs = rd_neg ? (EW'(0) - ram_rdata) : ram_rdata;
		mag    = rd_abs[IW-1:0];
		nxt    = cur_q + val_q[IW-1:0];

		case (st_q)
			S_CLEAR: begin
				// Segment map init: one free segment covering the whole heap.
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? NB_E : '0;
				clr_d     = clr_q + AW'(1);
				if (clr_q == CLR_LAST) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					op_d    = in_data.opcode;
					raddr_d = '0;
					if (in_data.opcode == OP_ALLOC) begin
						// Adding BLOCK_BYTES - 1 makes the floor division round up.
						stat_d = STAT_ALLOC_FAIL;
						div_d  = {8'd0, in_data.size_bytes} + BB_M1;
						st_d   = S_DIV;
					end else begin
						stat_d = STAT_FREE_ERR;
						div_d  = in_data.address - data_base_q;
						st_d   = (in_data.address < data_base_q) ? S_DONE : S_DIV;
					end
				end
			end
			S_DIV: begin
				// A dividend at or above the limit means more than NUM_BLOCKS blocks for
				// an allocate, or an index past the map for a free.
				if (div_q >= lim) begin
					st_d = S_DONE;
				end else begin
					need_d = quot;
					st_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (op_q == OP_ALLOC) begin
					cur_d = '0;
					st_d  = (need_q == '0) ? S_DONE : S_A_RD;
				end else begin
					cur_d = need_q;
					st_d  = S_F_RD;
				end
			end
			S_A_RD: begin
				ram_raddr = cur_q[AW-1:0];
				st_d      = (cur_q >= NB_I) ? S_DONE : S_A_EV;
			end
			S_A_EV: begin
				if (rd_pos && (mag >= need_q)) begin
					val_d = ram_rdata;
					st_d  = (mag > need_q) ? S_A_SPLIT : S_A_HEAD;
				end else begin
					cur_d = cur_q + ((ram_rdata == '0) ? IW'(1) : mag);
					st_d  = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				// The remainder of the segment becomes a new free segment.
				ram_we    = 1'b1;
				ram_waddr = AW'(cur_q + need_q);
				ram_wdata = val_q - {1'b0, need_q};
				st_d      = S_A_HEAD;
			end
			S_A_HEAD: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[AW-1:0];
				ram_wdata = EW'(0) - {1'b0, need_q};
				st_d      = S_A_MUL;
			end
			S_A_MUL: begin
				prod_d = {{BBW{1'b0}}, cur_q[AW-1:0]} * BB_P;
				st_d   = S_A_ADD;
			end
			S_A_ADD: begin
				raddr_d = data_base_q + 32'(prod_q);
				stat_d  = STAT_OK;
				st_d    = S_DONE;
			end
			S_F_RD: begin
				ram_raddr = cur_q[AW-1:0];
				st_d      = S_F_EV;
			end
			S_F_EV: begin
				if (!rd_neg) begin
					st_d = S_DONE;
				end else begin
					val_d     = rd_abs;
					ram_we    = 1'b1;
					ram_waddr = cur_q[AW-1:0];
					ram_wdata = rd_abs;
					p_d       = cur_q - IW'(1);
					st_d      = (cur_q == '0) ? S_N_RD : S_P_RD;
				end
			end
			S_P_RD: begin
				ram_raddr = p_q[AW-1:0];
				st_d      = S_P_EV;
			end
			S_P_EV: begin
				// Scan back over non-head entries to the previous segment head.
				if ((p_q != '0) && (ram_rdata == '0)) begin
					p_d  = p_q - IW'(1);
					st_d = S_P_RD;
				end else if (rd_pos) begin
					ram_we    = 1'b1;
					ram_waddr = p_q[AW-1:0];
					ram_wdata = ram_rdata + val_q;
					val_d     = ram_rdata + val_q;
					st_d      = S_P_ZERO;
				end else begin
					st_d = S_N_RD;
				end
			end
			S_P_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[AW-1:0];
				ram_wdata = '0;
				cur_d     = p_q;
				st_d      = S_N_RD;
			end
			S_N_RD: begin
				ram_raddr = nxt[AW-1:0];
				p_d       = nxt;
				if (nxt < NB_I) begin
					st_d = S_N_EV;
				end else begin
					stat_d = STAT_OK;
					st_d   = S_DONE;
				end
			end
			S_N_EV: begin
				if (rd_pos) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q[AW-1:0];
					ram_wdata = val_q + ram_rdata;
					st_d      = S_N_ZERO;
				end else begin
					stat_d = STAT_OK;
					st_d   = S_DONE;
				end
			end
			S_N_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = p_q[AW-1:0];
				ram_wdata = '0;
				stat_d    = STAT_OK;
				st_d      = S_DONE;
			end
			S_DONE: begin
				if (out_ready) begin
					st_d = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bmffa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Block map allocator port checker
// Concurrent assertions on the allocator's ports, bound into the allocator module.
// ----------------------------------------------------------------------------
module bmffa_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire bmffa_pkg::rsp_t out_data
);

	import bmffa_pkg::*;

	// A stalled result must stay put until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// Requests are taken one at a time: never while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("request accepted while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready again right after a request transfer");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STAT_OK) ||
			(out_data.status == STAT_ALLOC_FAIL) || (out_data.status == STAT_FREE_ERR))
		else $error("undefined status code");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != STAT_OK) |-> (out_data.result_address == '0))
		else $error("failed request returned a nonzero address");

endmodule

bind block_map_first_fit_allocator bmffa_checker u_bmffa_checker (.*);
`default_nettype wire
